// File: hdl/rwpp_pkg.sv
// Shared types and constants for the RIFF/WAVE PCM stream parser.
// No dependencies; imported by every other file of the block.
`default_nettype none

package rwpp_pkg;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_CHDR,
		PH_BODY,
		PH_PAD,
		PH_HALT
	} phase_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HDR    = 3'd1;
	localparam logic [2:0] ST_NOT_PCM    = 3'd2;
	localparam logic [2:0] ST_NO_FMT     = 3'd3;
	localparam logic [2:0] ST_NO_DATA    = 3'd4;
	localparam logic [2:0] ST_BAD_WIDTH  = 3'd5;
	localparam logic [2:0] ST_DATA_EARLY = 3'd6;

	// Four-character codes as they arrive, first byte in the low bits.
	localparam logic [31:0] RIFF_MAGIC = 32'h4646_4952;
	localparam logic [31:0] WAVE_MAGIC = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA   = 32'h6174_6164;

	localparam logic [3:0]  RIFF_HDR_LEN = 4'd12;
	localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] BITS_8       = 16'd8;
	localparam logic [15:0] BITS_16      = 16'd16;
	localparam logic [7:0]  U8_BIAS      = 8'h80;

	// Everything one input byte produces: an optional sample and an optional end report.
	typedef struct packed {
		logic        has_sample;
		logic [15:0] sample;
		logic        has_report;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [2:0]  status;
	} rec_t;

endpackage

`default_nettype wire

// File: hdl/rwpp_core.sv
// Parser state and its update for one byte of the WAV stream.
// Depends on rwpp_pkg for the phase type, codes and the result record.
`default_nettype none

module rwpp_core
	import rwpp_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        step,
	input  wire  [7:0] byte_value,
	input  wire        final_byte,
	output rec_t       rec
);

	phase_t      phase_q, n_phase;
	logic [3:0]  hdr_idx_q, n_hdr_idx;
	logic [31:0] tag_q, n_tag;
	logic [31:0] len_q, n_len;
	logic [31:0] left_q, n_left;
	logic        pad_q, n_pad;
	logic [63:0] fmt_cap_q, n_fmt_cap;
	logic        fmt_seen_q, n_fmt_seen;
	logic        data_seen_q, n_data_seen;
	logic [8:0]  hold_q, n_hold;
	logic [2:0]  err_q, n_err;
	logic [15:0] ch_q, n_ch;
	logic [31:0] rate_q, n_rate;
	logic [15:0] bits_q, n_bits;

	logic [31:0] body_off;
	logic [31:0] full_len;
	logic [31:0] left_dec;
	logic [2:0]  rpt_status;

	assign body_off = len_q - left_q;
	assign full_len = {byte_value, len_q[23:0]};
	assign left_dec = left_q - 32'd1;

	always_comb begin
		n_phase     = phase_q;
		n_hdr_idx   = hdr_idx_q;
		n_tag       = tag_q;
		n_len       = len_q;
		n_left      = left_q;
		n_pad       = pad_q;
		n_fmt_cap   = fmt_cap_q;
		n_fmt_seen  = fmt_seen_q;
		n_data_seen = data_seen_q;
		n_hold      = hold_q;
		n_err       = err_q;
		n_ch        = ch_q;
		n_rate      = rate_q;
		n_bits      = bits_q;
		rec         = '0;

		case (phase_q)
			PH_RIFF: begin
				if ((hdr_idx_q < 4'd4) &&
				    (byte_value != RIFF_MAGIC[{hdr_idx_q[1:0], 3'b000} +: 8])) begin
					if (n_err == ST_OK) n_err = ST_BAD_HDR;
					n_phase = PH_HALT;
				end else if ((hdr_idx_q >= 4'd8) &&
				    (byte_value != WAVE_MAGIC[{hdr_idx_q[1:0], 3'b000} +: 8])) begin
					if (n_err == ST_OK) n_err = ST_BAD_HDR;
					n_phase = PH_HALT;
				end else if (hdr_idx_q + 4'd1 >= RIFF_HDR_LEN) begin
					n_hdr_idx = '0;
					n_phase   = PH_CHDR;
				end else begin
					n_hdr_idx = hdr_idx_q + 4'd1;
				end
			end
			PH_CHDR: begin
				if (!hdr_idx_q[2]) begin
					if (hdr_idx_q[1:0] == 2'd0) n_tag = {24'd0, byte_value};
					else n_tag[{hdr_idx_q[1:0], 3'b000} +: 8] = byte_value;
				end else begin
					if (hdr_idx_q[1:0] == 2'd0) n_len = {24'd0, byte_value};
					else n_len[{hdr_idx_q[1:0], 3'b000} +: 8] = byte_value;
				end
				n_hdr_idx = {1'b0, hdr_idx_q[2:0] + 3'd1};
				if (hdr_idx_q[2:0] == 3'd7) begin
					n_left    = full_len;
					n_pad     = full_len[0];
					n_fmt_cap = '0;
					n_hold    = '0;
					n_phase   = (full_len == 32'd0) ? PH_CHDR : PH_BODY;
					if (tag_q == TAG_DATA) begin
						if (!fmt_seen_q) begin
							if (n_err == ST_OK) n_err = ST_DATA_EARLY;
							n_phase = PH_HALT;
						end else if (ch_q == 16'd0) begin
							if (n_err == ST_OK) n_err = ST_NO_FMT;
							n_phase = PH_HALT;
						end else if (!(bits_q inside {BITS_8, BITS_16})) begin
							if (n_err == ST_OK) n_err = ST_BAD_WIDTH;
							n_phase = PH_HALT;
						end
					end
				end
			end
			PH_BODY: begin
				if ((tag_q == TAG_FMT) && (len_q >= FMT_MIN_LEN)) begin
					if (body_off < 32'd8) begin
						n_fmt_cap[{body_off[2:0], 3'b000} +: 8] =
							fmt_cap_q[{body_off[2:0], 3'b000} +: 8] | byte_value;
					end else if (body_off == 32'd14) begin
						n_hold = {1'b1, byte_value};
					end else if (body_off == 32'd15) begin
						if (fmt_cap_q[15:0] != FMT_PCM) begin
							if (n_err == ST_OK) n_err = ST_NOT_PCM;
							n_phase = PH_HALT;
						end else begin
							n_ch       = fmt_cap_q[31:16];
							n_rate     = fmt_cap_q[63:32];
							n_bits     = {byte_value, hold_q[7:0]};
							n_fmt_seen = 1'b1;
						end
						n_hold = '0;
					end
				end else if (tag_q == TAG_DATA) begin
					n_data_seen = 1'b1;
					if (bits_q == BITS_8) begin
						rec.has_sample = 1'b1;
						rec.sample     = {byte_value ^ U8_BIAS, 8'h00};
					end else if (hold_q[8]) begin
						rec.has_sample = 1'b1;
						rec.sample     = {byte_value, hold_q[7:0]};
						n_hold         = '0;
					end else begin
						n_hold = {1'b1, byte_value};
					end
				end
				if (n_phase == PH_BODY) begin
					n_left = left_dec;
					if (left_dec == 32'd0) n_phase = pad_q ? PH_PAD : PH_CHDR;
				end
			end
			PH_PAD: begin
				n_pad   = 1'b0;
				n_phase = PH_CHDR;
			end
			default: begin
			end
		endcase

		rpt_status = n_err;
		if (n_err == ST_OK) begin
			if (n_phase == PH_RIFF) rpt_status = ST_BAD_HDR;
			else if (!n_fmt_seen || (n_ch == 16'd0)) rpt_status = ST_NO_FMT;
			else if (!n_data_seen) rpt_status = ST_NO_DATA;
			else if (!(n_bits inside {BITS_8, BITS_16})) rpt_status = ST_BAD_WIDTH;
		end
		rec.has_report = final_byte;
		if (final_byte) begin
			rec.channels = n_ch;
			rec.rate     = n_rate;
			rec.bits     = n_bits;
			rec.status   = rpt_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RIFF;
			hdr_idx_q   <= '0;
			tag_q       <= '0;
			len_q       <= '0;
			left_q      <= '0;
			pad_q       <= 1'b0;
			fmt_cap_q   <= '0;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
			hold_q      <= '0;
			err_q       <= ST_OK;
			ch_q        <= '0;
			rate_q      <= '0;
			bits_q      <= '0;
		end else if (step) begin
			if (final_byte) begin
				phase_q     <= PH_RIFF;
				hdr_idx_q   <= '0;
				tag_q       <= '0;
				len_q       <= '0;
				left_q      <= '0;
				pad_q       <= 1'b0;
				fmt_cap_q   <= '0;
				fmt_seen_q  <= 1'b0;
				data_seen_q <= 1'b0;
				hold_q      <= '0;
				err_q       <= ST_OK;
				ch_q        <= '0;
				rate_q      <= '0;
				bits_q      <= '0;
			end else begin
				phase_q     <= n_phase;
				hdr_idx_q   <= n_hdr_idx;
				tag_q       <= n_tag;
				len_q       <= n_len;
				left_q      <= n_left;
				pad_q       <= n_pad;
				fmt_cap_q   <= n_fmt_cap;
				fmt_seen_q  <= n_fmt_seen;
				data_seen_q <= n_data_seen;
				hold_q      <= n_hold;
				err_q       <= n_err;
				ch_q        <= n_ch;
				rate_q      <= n_rate;
				bits_q      <= n_bits;
			end
		end
	end

	a_halt_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT) |-> (err_q != ST_OK))
		else $error("Parser halted without an error code.");

	a_riff_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RIFF) |-> (hdr_idx_q < RIFF_HDR_LEN))
		else $error("Header index ran past the RIFF header.");

	a_pad_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAD) |-> pad_q)
		else $error("Pad phase entered with no pad byte pending.");

	a_body_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (left_q != 32'd0))
		else $error("Chunk body phase with no bytes left.");

endmodule

`default_nettype wire

// File: hdl/rwpp_outq.sv
// Two-entry queue of per-byte result records that serves them as output beats.
// Depends on rwpp_pkg for the result record type.
`default_nettype none

module rwpp_outq
	import rwpp_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  rec_t              rec_in,
	output logic              full,
	output logic              out_valid,
	input  wire               out_ready,
	output logic              item_kind,
	output logic signed [15:0] sample_value,
	output logic [15:0]       channel_count,
	output logic [31:0]       rate_hz,
	output logic [15:0]       sample_bits,
	output logic [2:0]        status,
	output logic              last_of_run
);

	rec_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       sent_q;
	rec_t       head;
	logic       sample_beat;
	logic       beat_done;
	logic       pop;

	assign head        = entry_q[rd_ptr_q];
	assign full        = (count_q == 2'd2);
	assign out_valid   = (count_q != 2'd0);
	assign sample_beat = head.has_sample && !sent_q;
	assign last_of_run = !(sample_beat && head.has_report);
	assign beat_done   = out_valid && out_ready;
	assign pop         = beat_done && last_of_run;

	assign item_kind     = !sample_beat;
	assign sample_value  = sample_beat ? $signed(head.sample) : 16'sd0;
	assign channel_count = sample_beat ? 16'd0 : head.channels;
	assign rate_hz       = sample_beat ? 32'd0 : head.rate;
	assign sample_bits   = sample_beat ? 16'd0 : head.bits;
	assign status        = sample_beat ? ST_OK : head.status;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= rec_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
			sent_q   <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
			if (pop) sent_q <= 1'b0;
			else if (beat_done && sample_beat) sent_q <= 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("Result queue count out of range.");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("Record pushed into a full result queue.");

	a_report_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind) |-> last_of_run)
		else $error("End report not marked as the last beat of its byte.");

	a_sent_has_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sent_q) |-> (head.has_sample && head.has_report))
		else $error("Sample marked sent on a record without a pending report.");

endmodule

`default_nettype wire

// File: hdl/riff_wave_pcm_stream_parser_top.sv
// Top level of the RIFF/WAVE PCM stream parser: input register, parser core, result queue.
// Depends on rwpp_pkg, rwpp_core and rwpp_outq.
//
//   Channel | Handshake            | Beat contents
//   --------+----------------------+---------------------------------------------------
//   input   | in_valid / in_ready  | byte_value, final_byte
//   output  | out_valid / out_ready| item_kind, sample_value, channel_count, rate_hz,
//           |                      | sample_bits, status, last_of_run
//
// A byte waits in the input register after acceptance until taken by the parser, which
// updates its state and writes the byte's sample and end report into the result queue in that same cycle.
// Bytes are accepted every cycle while the result queue is not full; a byte that yields
// a sample and a report needs two beats, else the sustained rate is one byte per cycle.
// Reset clears the parser to the start of a file; the final byte also returns it there.
// When the output stalls, the two-entry queue fills and then the input register holds.
`default_nettype none

module riff_wave_pcm_stream_parser_top
	import rwpp_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [7:0]        byte_value,
	input  wire               final_byte,
	output logic              out_valid,
	input  wire               out_ready,
	output logic              item_kind,
	output logic signed [15:0] sample_value,
	output logic [15:0]       channel_count,
	output logic [31:0]       rate_hz,
	output logic [15:0]       sample_bits,
	output logic [2:0]        status,
	output logic              last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       q_full;
	logic       fire;
	logic       push;
	rec_t       rec;

	assign fire     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || fire;
	assign push     = fire && (rec.has_sample || rec.has_report);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= byte_value;
			final_s1 <= final_byte;
		end
	end

	rwpp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.byte_value (byte_s1),
		.final_byte (final_s1),
		.rec        (rec)
	);

	rwpp_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.rec_in        (rec),
		.full          (q_full),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_kind     (item_kind),
		.sample_value  (sample_value),
		.channel_count (channel_count),
		.rate_hz       (rate_hz),
		.sample_bits   (sample_bits),
		.status        (status),
		.last_of_run   (last_of_run)
	);

	a_final_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && final_s1) |-> push)
		else $error("Final byte did not produce an end report.");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(byte_s1) && $stable(final_s1)))
		else $error("Input register lost a stalled byte.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("Input not ready with an empty input register.");

endmodule

`default_nettype wire

// File: tb/tb_riff_wave_pcm_stream_parser_top.sv
// Self-checking testbench for riff_wave_pcm_stream_parser_top: WAV files go in byte by byte and
// every sample and end report is checked against a behavioral parser kept in this file.
// Depends on rwpp_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module tb_riff_wave_pcm_stream_parser_top;
	import rwpp_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BYTES = 100;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_CYCLES = 60;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] RIFX_MAGIC = 32'h5846_4952;
	localparam logic [31:0] WAVX_MAGIC = 32'h5856_4157;

	typedef struct packed {
		logic        kind;
		logic [15:0] sample;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] fmt_bits;
		logic [2:0]  status;
		logic        last;
	} wav_beat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] byte_value;
	logic final_byte;
	logic out_valid;
	logic out_ready;
	logic item_kind;
	logic signed [15:0] sample_value;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [15:0] sample_bits;
	logic [2:0] status;
	logic last_of_run;

	wav_beat_t wanted_beats[$];
	wav_beat_t got_want;
	logic [7:0] file_bytes[$];
	int fail_count = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	int rx_hold_cycles = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;

	phase_t      wav_phase;
	logic [3:0]  wav_hdr_idx;
	logic [31:0] wav_tag;
	logic [31:0] wav_len;
	logic [31:0] wav_left;
	logic        wav_pad;
	logic [63:0] wav_fmt;
	logic        wav_fmt_seen;
	logic        wav_data_seen;
	logic [8:0]  wav_hold;
	logic [2:0]  wav_err;
	logic [15:0] wav_channels;
	logic [31:0] wav_rate;
	logic [15:0] wav_bits;

	riff_wave_pcm_stream_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.sample_value(sample_value),
		.channel_count(channel_count),
		.rate_hz(rate_hz),
		.sample_bits(sample_bits),
		.status(status),
		.last_of_run(last_of_run)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void clear_parser();
		wav_phase = PH_RIFF;
		wav_hdr_idx = '0;
		wav_tag = '0;
		wav_len = '0;
		wav_left = '0;
		wav_pad = 1'b0;
		wav_fmt = '0;
		wav_fmt_seen = 1'b0;
		wav_data_seen = 1'b0;
		wav_hold = '0;
		wav_err = ST_OK;
		wav_channels = '0;
		wav_rate = '0;
		wav_bits = '0;
	endfunction

	function automatic void raise_status(logic [2:0] code);
		if (wav_err == ST_OK) begin
			wav_err = code;
		end
		wav_phase = PH_HALT;
	endfunction

	function automatic logic width_ok();
		return wav_bits == BITS_8 || wav_bits == BITS_16;
	endfunction

	// Advances the parser by one byte and queues the samples and report that byte yields.
	function automatic void parse_wav_byte(logic [7:0] b, logic fin);
		wav_beat_t res [2];
		int n;
		int i;
		logic [31:0] off;
		logic [2:0] st;
		n = 0;
		case (wav_phase)
		PH_RIFF: begin
			i = int'(wav_hdr_idx);
			if (i < 4 && b != RIFF_MAGIC[8*i +: 8]) begin
				raise_status(ST_BAD_HDR);
			end else if (i >= 8 && i < 12 && b != WAVE_MAGIC[8*(i-8) +: 8]) begin
				raise_status(ST_BAD_HDR);
			end else begin
				wav_hdr_idx = wav_hdr_idx + 4'd1;
				if (wav_hdr_idx >= RIFF_HDR_LEN) begin
					wav_hdr_idx = '0;
					wav_phase = PH_CHDR;
				end
			end
		end
		PH_CHDR: begin
			i = int'(wav_hdr_idx[2:0]);
			if (i < 4) begin
				if (i == 0) wav_tag = '0;
				wav_tag[8*i +: 8] = b;
			end else begin
				if (i == 4) wav_len = '0;
				wav_len[8*(i-4) +: 8] = b;
			end
			wav_hdr_idx = 4'((i + 1) % 8);
			if (i == 7) begin
				wav_left = wav_len;
				wav_pad = wav_len[0];
				wav_fmt = '0;
				wav_hold = '0;
				if (wav_len == 0) wav_phase = PH_CHDR;
				else wav_phase = PH_BODY;
				if (wav_tag == TAG_DATA) begin
					if (!wav_fmt_seen) raise_status(ST_DATA_EARLY);
					else if (wav_channels == 0) raise_status(ST_NO_FMT);
					else if (!width_ok()) raise_status(ST_BAD_WIDTH);
				end
			end
		end
		PH_BODY: begin
			off = wav_len - wav_left;
			if (wav_tag == TAG_FMT && wav_len >= FMT_MIN_LEN) begin
				if (off < 8) begin
					wav_fmt[8*off +: 8] = b;
				end else if (off == 14) begin
					wav_hold = {1'b1, b};
				end else if (off == 15) begin
					if (wav_fmt[15:0] != FMT_PCM) begin
						raise_status(ST_NOT_PCM);
					end else begin
						wav_channels = wav_fmt[31:16];
						wav_rate = wav_fmt[63:32];
						wav_bits = {b, wav_hold[7:0]};
						wav_fmt_seen = 1'b1;
					end
					wav_hold = '0;
				end
			end else if (wav_tag == TAG_DATA) begin
				wav_data_seen = 1'b1;
				if (wav_bits == BITS_8) begin
					res[n] = '0;
					res[n].sample = {b ^ U8_BIAS, 8'h00};
					n++;
				end else if (wav_hold[8]) begin
					res[n] = '0;
					res[n].sample = {b, wav_hold[7:0]};
					n++;
					wav_hold = '0;
				end else begin
					wav_hold = {1'b1, b};
				end
			end
			if (wav_phase == PH_BODY) begin
				wav_left = wav_left - 1;
				if (wav_left == 0) begin
					if (wav_pad) wav_phase = PH_PAD;
					else wav_phase = PH_CHDR;
				end
			end
		end
		PH_PAD: begin
			wav_pad = 1'b0;
			wav_phase = PH_CHDR;
		end
		default: begin
		end
		endcase
		if (fin) begin
			st = wav_err;
			if (st == ST_OK) begin
				if (wav_phase == PH_RIFF) st = ST_BAD_HDR;
				else if (!wav_fmt_seen || wav_channels == 0) st = ST_NO_FMT;
				else if (!wav_data_seen) st = ST_NO_DATA;
				else if (!width_ok()) st = ST_BAD_WIDTH;
			end
			res[n] = '0;
			res[n].kind = 1'b1;
			res[n].channels = wav_channels;
			res[n].rate = wav_rate;
			res[n].fmt_bits = wav_bits;
			res[n].status = st;
			n++;
			clear_parser();
		end
		for (int k = 0; k < n; k++) begin
			res[k].last = (k == n - 1);
			wanted_beats = {wanted_beats, res[k]};
		end
	endfunction

	function automatic void append_byte(logic [7:0] v);
		file_bytes = {file_bytes, v};
	endfunction

	function automatic void put_le(logic [31:0] v, int n);
		for (int k = 0; k < n; k++) begin
			append_byte(v[8*k +: 8]);
		end
	endfunction

	function automatic void put_riff_header();
		logic [31:0] riff_len;
		riff_len = $urandom;
		put_le(RIFF_MAGIC, 4);
		put_le(riff_len, 4);
		put_le(WAVE_MAGIC, 4);
	endfunction

	function automatic void put_chunk_header(logic [31:0] tag, logic [31:0] len);
		put_le(tag, 4);
		put_le(len, 4);
	endfunction

	function automatic void put_body(int n);
		logic [7:0] r;
		for (int k = 0; k < n + (n % 2); k++) begin
			r = 8'($urandom);
			append_byte(r);
		end
	endfunction

	function automatic void put_fmt(logic [31:0] len, logic [15:0] tag, logic [15:0] ch,
			logic [31:0] rate, logic [15:0] fb);
		logic [127:0] body;
		logic [15:0] align;
		logic [31:0] byte_rate;
		logic [7:0] r;
		align = 16'($urandom);
		byte_rate = $urandom;
		body = {fb, align, byte_rate, rate, ch, tag};
		put_chunk_header(TAG_FMT, len);
		for (int off = 0; off < len; off++) begin
			r = 8'($urandom);
			append_byte(off < 16 ? body[8*off +: 8] : r);
		end
		if (len[0]) append_byte(8'h00);
	endfunction

	function automatic void put_data(int n);
		put_chunk_header(TAG_DATA, n);
		put_body(n);
	endfunction

	function automatic void put_junk(int n);
		logic [31:0] tag;
		tag = $urandom_range(0, 1) ? TAG_LIST : $urandom;
		put_chunk_header(tag, n);
		put_body(n);
	endfunction

	function automatic void put_random_fmt();
		logic [31:0] len;
		logic [15:0] tag;
		logic [15:0] ch;
		logic [15:0] fb;
		logic [31:0] rate;
		int pick;
		len = FMT_MIN_LEN;
		if ($urandom_range(0, 3) == 0) len = len + $urandom_range(1, 4);
		tag = FMT_PCM;
		if ($urandom_range(0, 11) == 0) tag = 16'($urandom);
		pick = $urandom_range(0, 19);
		if (pick == 0) ch = 16'd0;
		else if (pick < 3) ch = 16'($urandom);
		else ch = 16'($urandom_range(1, 2));
		rate = $urandom;
		pick = $urandom_range(0, 11);
		if (pick == 0) fb = 16'($urandom_range(0, 40));
		else if (pick < 6) fb = BITS_8;
		else fb = BITS_16;
		put_fmt(len, tag, ch, rate, fb);
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			fail_count++;
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic fin);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		final_byte <= fin;
		parse_wav_byte(b, fin);
		bytes_sent++;
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int k = 0; k < file_bytes.size(); k++) begin
			send_byte(file_bytes[k], k == file_bytes.size() - 1);
		end
		file_bytes.delete();
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (wanted_beats.size() != 0) @(negedge clk);
	endtask

	task automatic test_pcm16_stereo();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd2, 32'd44100, BITS_16);
		put_chunk_header(TAG_DATA, 8);
		put_le(32'hFFFF_0000, 4);
		put_le(32'h7FFF_8000, 4);
		send_file();
	endtask

	task automatic test_u8_extremes();
		put_riff_header();
		put_junk(3);
		put_fmt(18, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, BITS_8);
		put_chunk_header(TAG_DATA, 4);
		put_le(32'h7FFF_8000, 4);
		put_data(3);
		send_file();
	endtask

	task automatic test_unpaired_bytes();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd8000, BITS_16);
		put_data(3);
		put_data(2);
		put_data(0);
		send_file();
	endtask

	task automatic test_header_errors();
		put_le(RIFX_MAGIC, 4);
		put_body(10);
		send_file();
		put_le(RIFF_MAGIC, 4);
		put_body(4);
		put_le(WAVX_MAGIC, 4);
		put_data(2);
		send_file();
		put_le(RIFF_MAGIC, 4);
		put_body(1);
		send_file();
		append_byte(8'h52);
		send_file();
	endtask

	task automatic test_fmt_errors();
		put_riff_header();
		put_fmt(16, 16'd3, 16'd2, 32'd48000, BITS_16);
		send_file();
		put_riff_header();
		put_fmt(14, FMT_PCM, 16'd1, 32'd8000, BITS_8);
		put_data(2);
		send_file();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd0, 32'd8000, BITS_8);
		put_data(2);
		send_file();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd8000, 16'd12);
		put_data(2);
		send_file();
	endtask

	task automatic test_end_checks();
		put_riff_header();
		send_file();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd22050, 16'd24);
		send_file();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd22050, BITS_8);
		put_data(2);
		put_fmt(16, FMT_PCM, 16'd1, 32'd22050, 16'd24);
		send_file();
		put_riff_header();
		put_data(2);
		put_fmt(16, FMT_PCM, 16'd1, 32'd8000, BITS_8);
		send_file();
		put_riff_header();
		put_chunk_header(TAG_FMT, 16);
		put_body(10);
		send_file();
	endtask

	task automatic test_fmt_replace_and_truncation();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd8000, BITS_8);
		put_fmt(17, FMT_PCM, 16'd2, 32'd96000, BITS_16);
		put_data(4);
		put_chunk_header(TAG_DATA, 32'hFFFF_FFFF);
		put_body(6);
		send_file();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd8000, BITS_8);
		put_data(2);
		put_le(TAG_LIST, 4);
		put_le(32'h0000_0003, 1);
		send_file();
	endtask

	task automatic test_output_stall();
		rx_hold_cycles = STALL_CYCLES;
		tx_burst = 1;
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd1, 32'd11025, BITS_8);
		put_data(24);
		send_file();
		tx_burst = 0;
	endtask

	task automatic test_pause_until_drained();
		put_riff_header();
		put_fmt(16, FMT_PCM, 16'd2, 32'd32000, BITS_16);
		put_data(12);
		send_file();
		wait_for_drain();
	endtask

	task automatic test_random_files();
		int target;
		int pick;
		int pos;
		int cut;
		logic [7:0] r;
		target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < target) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				if (pick < 4) put_le(RIFF_MAGIC, 4);
				put_body($urandom_range(1, 16));
			end else begin
				put_riff_header();
				if ($urandom_range(0, 3) == 0) put_junk($urandom_range(0, 7));
				if ($urandom_range(0, 19) == 0) put_data($urandom_range(0, 6));
				put_random_fmt();
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 4) == 0) put_junk($urandom_range(0, 5));
					if ($urandom_range(0, 9) == 0) put_random_fmt();
					put_data($urandom_range(0, 16));
				end
			end
			if ($urandom_range(0, 6) == 0) begin
				pos = $urandom_range(0, file_bytes.size() - 1);
				r = 8'($urandom);
				file_bytes[pos] = r;
			end
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, file_bytes.size());
				while (file_bytes.size() > cut) void'(file_bytes.pop_back());
			end
			send_file();
			if ($urandom_range(0, 9) == 0) wait_for_drain();
		end
		tx_burst = 0;
		rx_burst = 0;
	endtask

	initial begin
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end
			wait_cycles = rx_burst ? 0 : $urandom_range(0, 4);
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready) && rx_hold_cycles == 0);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (wanted_beats.size() == 0) begin
				$error("unexpected beat: item_kind %0d, sample_value %0h, status %0d",
					item_kind, sample_value, status);
				fail_count++;
			end else begin
				got_want = wanted_beats.pop_front();
				check_field("item_kind", 32'(got_want.kind), 32'(item_kind));
				check_field("sample_value", 32'(got_want.sample),
					32'($unsigned(sample_value)));
				check_field("channel_count", 32'(got_want.channels), 32'(channel_count));
				check_field("rate_hz", got_want.rate, rate_hz);
				check_field("sample_bits", 32'(got_want.fmt_bits), 32'(sample_bits));
				check_field("status", 32'(got_want.status), 32'(status));
				check_field("last_of_run", 32'(got_want.last), 32'(last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_value = 8'h00;
		final_byte = 1'b0;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_pcm16_stereo();
		test_u8_extremes();
		test_unpaired_bytes();
		test_header_errors();
		test_fmt_errors();
		test_end_checks();
		test_fmt_replace_and_truncation();
		test_output_stall();
		test_pause_until_drained();
		test_random_files();
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/rwpp_pkg.sv
hdl/rwpp_core.sv
hdl/rwpp_outq.sv
hdl/riff_wave_pcm_stream_parser_top.sv
tb/tb_riff_wave_pcm_stream_parser_top.sv
